// ----- hdl/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants of the pedometer: filter coefficients, register
// indexes, activity codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package ped_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned DIV_W  = 32;
  localparam int unsigned PEAK_W = 24;

  // band-pass biquad, Q2.30
  localparam logic signed [25:0] COEF_B0  = 26'sd32715568;
  localparam logic signed [32:0] COEF_A1N = 33'sd2066654675;  // minus a1
  localparam logic signed [31:0] COEF_A2  = 32'sd1008310688;
  localparam logic signed [17:0] ONE_G    = 18'sd4096;

  localparam logic signed [39:0] DELAY_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] DELAY_MIN = -40'sh80_0000_0000;

  typedef enum logic [2:0] {
    REG_NOISE_FLOOR = 3'd0,
    REG_DEBOUNCE    = 3'd1,
    REG_ACT_WINDOW  = 3'd2,
    REG_RUN_CROSS   = 3'd3,
    REG_CAD_TIMEOUT = 3'd4,
    REG_TICKS_MIN   = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_IDLE    = 2'd0,
    ACT_WALKING = 2'd1,
    ACT_RUNNING = 2'd2
  } activity_e;

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_SQ   = 17'h00002,
    ST_SQRT = 17'h00004,
    ST_F0   = 17'h00008,
    ST_F1   = 17'h00010,
    ST_F2   = 17'h00020,
    ST_F3   = 17'h00040,
    ST_F4   = 17'h00080,
    ST_THR  = 17'h00100,
    ST_THRW = 17'h00200,
    ST_PEAK = 17'h00400,
    ST_STEP = 17'h00800,
    ST_RD   = 17'h01000,
    ST_CST  = 17'h02000,
    ST_CW   = 17'h04000,
    ST_TO   = 17'h08000,
    ST_OUT  = 17'h10000
  } state_e;

  typedef enum logic {
    DIV_THRESHOLD = 1'b0,
    DIV_CADENCE   = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       sqrt_en;
    logic       f0;
    logic       f1;
    logic       f2;
    logic       f3;
    logic       f4;
    logic       div_start;
    div_sel_e   div_sel;
    logic       thr_set;
    logic       thr_use_div;
    logic       peak_upd;
    logic       step_upd;
    logic       cad_take;
    logic       timeout;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_peaks;
    logic step_now;
    logic held2;
    logic dt_zero;
    logic out_free;
  } sts_t;

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [39:0] r;
    if (v > 64'(DELAY_MAX))      r = DELAY_MAX;
    else if (v < 64'(DELAY_MIN)) r = DELAY_MIN;
    else                         r = v[39:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ped_ram.sv -----
// ----------------------------------------------------------------------------
// ped_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hdl/ped_div.sv -----
// ----------------------------------------------------------------------------
// ped_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [ped_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [ped_pkg::DIV_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [ped_pkg::DIV_W-1:0]      quotient_o
);

  localparam int unsigned W  = ped_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W:0]    rem_q, rem_d, trial;
  logic [W-1:0]  quo_q, quo_d, dvs_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[W-1:0], quo_q[W-1]};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = CW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- hdl/ped_dp.sv -----
// ----------------------------------------------------------------------------
// ped_dp
// Pedometer datapath: magnitude, biquad, peak store, threshold, step and
// cadence bookkeeping, activity window, config registers, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_dp #(
  parameter int unsigned PEAK_DEPTH    = 8,
  parameter int unsigned CADENCE_DEPTH = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ped_pkg::cmd_t cmd_i,
  output ped_pkg::sts_t      sts_o,
  input  wire logic [47:0]   s_axis_tdata,
  input  wire logic          cfg_valid_i,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [15:0]   cfg_data_i,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [55:0]        m_axis_tdata
);

  localparam int unsigned PAW = (PEAK_DEPTH > 1) ? $clog2(PEAK_DEPTH) : 1;
  localparam int unsigned PCW = $clog2(PEAK_DEPTH + 1);
  localparam int unsigned PSW = ped_pkg::PEAK_W + PCW;
  localparam int unsigned TAW = $clog2(CADENCE_DEPTH);
  localparam int unsigned THW = $clog2(CADENCE_DEPTH + 1);

  // config
  logic [11:0] nf_q;
  logic [9:0]  deb_q;
  logic [15:0] aw_q, tmo_q, tpm_q;
  logic [7:0]  rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nf_q  <= 12'd82;
      deb_q <= 10'd30;
      aw_q  <= 16'd100;
      rc_q  <= 8'd3;
      tmo_q <= 16'd200;
      tpm_q <= 16'd6000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ped_pkg::REG_NOISE_FLOOR: nf_q  <= cfg_data_i[11:0];
        ped_pkg::REG_DEBOUNCE:    deb_q <= cfg_data_i[9:0];
        ped_pkg::REG_ACT_WINDOW:  aw_q  <= cfg_data_i;
        ped_pkg::REG_RUN_CROSS:   rc_q  <= cfg_data_i[7:0];
        ped_pkg::REG_CAD_TIMEOUT: tmo_q <= cfg_data_i;
        ped_pkg::REG_TICKS_MIN:   tpm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // magnitude: squares through one shared multiplier, then bit-pair sqrt
  logic signed [15:0] ax_q, ay_q, az_q, sq_op;
  logic signed [31:0] sq_prod;
  logic [31:0] sq_q, sqv_q, root_q, bit_q, rb;
  logic signed [17:0] mag_s;

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_op = ax_q;
      2'd1:    sq_op = ay_q;
      default: sq_op = az_q;
    endcase
  end
  assign sq_prod = sq_op * sq_op;
  assign rb      = root_q + bit_q;
  assign mag_s   = $signed({1'b0, root_q[16:0]}) - ped_pkg::ONE_G;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q <= s_axis_tdata[15:0];
      ay_q <= s_axis_tdata[31:16];
      az_q <= s_axis_tdata[47:32];
      sq_q <= '0;
    end
    if (cmd_i.sq_en) begin
      sq_q <= sq_q + sq_prod;
      if (cmd_i.sq_sel == 2'd2) begin
        sqv_q  <= sq_q + sq_prod;
        root_q <= '0;
        bit_q  <= 32'h4000_0000;
      end
    end
    if (cmd_i.sqrt_en) begin
      if (sqv_q >= rb) begin
        sqv_q  <= sqv_q - rb;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // biquad, transposed direct form II, products formed one at a time
  logic signed [43:0] p0_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [55:0] ysum;
  logic signed [31:0] y_q;
  logic signed [39:0] d1_q, d2_q;

  assign ysum = 56'(p0_q) + (56'(d1_q) <<< 14) + 56'sd536870912;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (cmd_i.f4) begin
      d1_q <= ped_pkg::sat40(((p1_q + 64'sd8192) >>> 14) + 64'(d2_q));
      d2_q <= ped_pkg::sat40((-64'(p0_q) - p2_q + 64'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.f0) p0_q <= 44'(ped_pkg::COEF_B0) * 44'(mag_s);
    if (cmd_i.f1) y_q  <= 32'(ysum >>> 30);
    if (cmd_i.f2) p1_q <= 64'(ped_pkg::COEF_A1N) * 64'(y_q);
    if (cmd_i.f3) p2_q <= 64'(ped_pkg::COEF_A2) * 64'(y_q);
  end

  // shared divider
  logic [31:0] div_a, div_b, quo;
  logic        div_busy, div_done;
  logic [PSW-1:0] psum_q;
  logic [PCW-1:0] pcnt_q;
  logic [THW-1:0] held_q;
  logic [31:0] tick_q, stamp_rd, dt;
  logic [22:0] cad_num;

  assign cad_num = 23'(held_q - THW'(1)) * 23'(tpm_q);
  assign dt      = tick_q - stamp_rd;

  always_comb begin
    case (cmd_i.div_sel)
      ped_pkg::DIV_CADENCE: begin
        div_a = 32'(cad_num);
        div_b = dt;
      end
      default: begin
        div_a = 32'(psum_q);
        div_b = 32'(pcnt_q);
      end
    endcase
  end

  ped_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // threshold
  logic [23:0] thr_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_set) begin
      if (cmd_i.thr_use_div && quo[23:0] > 24'(nf_q)) thr_q <= quo[23:0];
      else                                            thr_q <= 24'(nf_q);
    end
  end

  // peak store
  logic signed [31:0] last_q, second_q;
  logic [PAW-1:0]     pidx_q;
  logic [PEAK_DEPTH-1:0] pvld_q;
  logic [23:0]        prd, pold, pval;
  logic               is_peak;

  assign is_peak = (last_q > second_q) && (last_q > y_q) && (last_q > 32'sd0);
  assign pval    = (last_q > 32'sd16777215) ? 24'hFF_FFFF : last_q[23:0];
  assign pold    = pvld_q[pidx_q] ? prd : 24'd0;

  ped_ram #(.WIDTH(24), .DEPTH(PEAK_DEPTH)) u_peak_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.peak_upd && is_peak),
    .waddr_i (pidx_q),
    .wdata_i (pval),
    .raddr_i (pidx_q),
    .rdata_o (prd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pidx_q <= '0;
      pvld_q <= '0;
      psum_q <= '0;
      pcnt_q <= '0;
    end else if (cmd_i.peak_upd && is_peak) begin
      psum_q         <= psum_q - PSW'(pold) + PSW'(pval);
      pvld_q[pidx_q] <= 1'b1;
      pidx_q         <= (32'(pidx_q) == PEAK_DEPTH - 1) ? '0 : pidx_q + 1'b1;
      if (32'(pcnt_q) < PEAK_DEPTH) pcnt_q <= pcnt_q + 1'b1;
    end
  end

  // crossing, window, lockout, steps
  logic signed [32:0] thr_s;
  logic        crossed, seen_n, seen_q;
  logic [15:0] wt_q, wc_q, wt_n, wc_n;
  logic [9:0]  lock_q, lock_n;
  logic [31:0] steps_q, stamp_last_q;
  logic [1:0]  act_q;
  logic [15:0] cad_q;
  logic [TAW-1:0] tidx_q, oldest;
  logic [THW:0]   otmp;

  assign thr_s   = $signed({9'b0, thr_q});
  assign crossed = (thr_q != '0) && (33'(last_q) <= thr_s) && (33'(y_q) > thr_s);
  assign wt_n    = wt_q + 1'b1;
  assign wc_n    = (crossed && wc_q != 16'hFFFF) ? wc_q + 1'b1 : wc_q;
  assign lock_n  = (lock_q != '0) ? lock_q - 1'b1 : lock_q;
  assign seen_n  = (lock_n == '0) && crossed;

  // oldest stamp sits held entries behind the write index
  always_comb begin
    if ((THW + 1)'(tidx_q) >= (THW + 1)'(held_q))
      otmp = (THW + 1)'(tidx_q) - (THW + 1)'(held_q);
    else
      otmp = (THW + 1)'(tidx_q) + (THW + 1)'(CADENCE_DEPTH) - (THW + 1)'(held_q);
  end
  assign oldest = otmp[TAW-1:0];

  ped_ram #(.WIDTH(32), .DEPTH(CADENCE_DEPTH)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.step_upd && seen_n),
    .waddr_i (tidx_q),
    .wdata_i (tick_q),
    .raddr_i (oldest),
    .rdata_o (stamp_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      last_q   <= '0;
      second_q <= '0;
      wt_q     <= '0;
      wc_q     <= '0;
      act_q    <= ped_pkg::ACT_IDLE;
      lock_q   <= '0;
      steps_q  <= '0;
      seen_q   <= 1'b0;
      tidx_q   <= '0;
      held_q   <= '0;
      cad_q    <= '0;
      stamp_last_q <= '0;
    end else begin
      if (cmd_i.load) tick_q <= tick_q + 1'b1;
      if (cmd_i.step_upd) begin
        if (wt_n >= aw_q) begin
          if (wc_n == '0)             act_q <= ped_pkg::ACT_IDLE;
          else if (wc_n < 16'(rc_q))  act_q <= ped_pkg::ACT_WALKING;
          else                        act_q <= ped_pkg::ACT_RUNNING;
          wt_q <= '0;
          wc_q <= '0;
        end else begin
          wt_q <= wt_n;
          wc_q <= wc_n;
        end
        seen_q   <= seen_n;
        second_q <= last_q;
        last_q   <= y_q;
        if (seen_n) begin
          steps_q      <= steps_q + 1'b1;
          lock_q       <= deb_q;
          stamp_last_q <= tick_q;
          tidx_q       <= (32'(tidx_q) == CADENCE_DEPTH - 1) ? '0 : tidx_q + 1'b1;
          if (32'(held_q) < CADENCE_DEPTH) held_q <= held_q + 1'b1;
          if (held_q == '0) cad_q <= '0;  // fewer than two stamps after this one
        end else begin
          lock_q <= lock_n;
        end
      end
      if (cmd_i.cad_take) begin
        cad_q <= (quo[31:16] != '0) ? 16'hFFFF : quo[15:0];
      end
      if (cmd_i.timeout && held_q != '0 &&
          (tick_q - stamp_last_q) > 32'(tmo_q)) begin
        cad_q <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd_i.fin) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) m_axis_tdata <= {5'b0, act_q, cad_q, steps_q, seen_q};
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.has_peaks = (pcnt_q != '0);
  assign sts_o.step_now  = seen_q;
  assign sts_o.held2     = (held_q >= THW'(2));
  assign sts_o.dt_zero   = (dt == '0);
  assign sts_o.out_free  = !m_axis_tvalid || m_axis_tready;

  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending one");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_held_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_q) <= CADENCE_DEPTH)
    else $error("stamp count above depth");
  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step_upd && seen_n) |=> (steps_q == $past(steps_q) + 32'd1))
    else $error("step not counted");

endmodule
`default_nettype wire

// ----- hdl/ped_ctrl.sv -----
// ----------------------------------------------------------------------------
// ped_ctrl
// Sequencer: walks one sample through squares, sqrt, filter, threshold,
// peak, step, cadence and timeout, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none
module ped_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire ped_pkg::sts_t sts_i,
  output ped_pkg::cmd_t      cmd_o
);

  ped_pkg::state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ped_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ped_pkg::ST_SQ;
        end
      end
      ped_pkg::ST_SQ: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = cnt_q[1:0];
        if (cnt_q == 4'd2) begin
          cnt_d   = '0;
          state_d = ped_pkg::ST_SQRT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ped_pkg::ST_SQRT: begin
        cmd_o.sqrt_en = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == 4'd15) state_d = ped_pkg::ST_F0;
      end
      ped_pkg::ST_F0: begin
        cmd_o.f0 = 1'b1;
        state_d  = ped_pkg::ST_F1;
      end
      ped_pkg::ST_F1: begin
        cmd_o.f1 = 1'b1;
        state_d  = ped_pkg::ST_F2;
      end
      ped_pkg::ST_F2: begin
        cmd_o.f2 = 1'b1;
        state_d  = ped_pkg::ST_F3;
      end
      ped_pkg::ST_F3: begin
        cmd_o.f3 = 1'b1;
        state_d  = ped_pkg::ST_F4;
      end
      ped_pkg::ST_F4: begin
        cmd_o.f4 = 1'b1;
        state_d  = ped_pkg::ST_THR;
      end
      ped_pkg::ST_THR: begin
        if (sts_i.has_peaks) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = ped_pkg::DIV_THRESHOLD;
          state_d         = ped_pkg::ST_THRW;
        end else begin
          cmd_o.thr_set = 1'b1;
          state_d       = ped_pkg::ST_PEAK;
        end
      end
      ped_pkg::ST_THRW: begin
        if (sts_i.div_done) begin
          cmd_o.thr_set     = 1'b1;
          cmd_o.thr_use_div = 1'b1;
          state_d           = ped_pkg::ST_PEAK;
        end
      end
      ped_pkg::ST_PEAK: begin
        cmd_o.peak_upd = 1'b1;
        state_d        = ped_pkg::ST_STEP;
      end
      ped_pkg::ST_STEP: begin
        cmd_o.step_upd = 1'b1;
        state_d        = ped_pkg::ST_RD;
      end
      ped_pkg::ST_RD: begin
        // stamp RAM read of the oldest entry happens in this cycle
        state_d = (sts_i.step_now && sts_i.held2) ? ped_pkg::ST_CST : ped_pkg::ST_TO;
      end
      ped_pkg::ST_CST: begin
        if (sts_i.dt_zero) begin
          state_d = ped_pkg::ST_TO;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = ped_pkg::DIV_CADENCE;
          state_d         = ped_pkg::ST_CW;
        end
      end
      ped_pkg::ST_CW: begin
        cmd_o.div_sel = ped_pkg::DIV_CADENCE;
        if (sts_i.div_done) begin
          cmd_o.cad_take = 1'b1;
          state_d        = ped_pkg::ST_TO;
        end
      end
      ped_pkg::ST_TO: begin
        cmd_o.timeout = 1'b1;
        state_d       = ped_pkg::ST_OUT;
      end
      ped_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ped_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ped_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ped_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign s_axis_tready = (state_q == ped_pkg::ST_IDLE);

  a_sqrt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ped_pkg::ST_SQRT && cnt_q == 4'd15) |=> (state_q == ped_pkg::ST_F0))
    else $error("sqrt sequence length wrong");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ped_pkg::ST_SQ && cnt_q == 4'd0))
    else $error("sample load out of sequence");

endmodule
`default_nettype wire

// ----- hdl/pedometer_step_cadence_activity_top.sv -----
// ----------------------------------------------------------------------------
// pedometer_step_cadence_activity_top
// Step counter, cadence and activity classifier for a 3-axis accelerometer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                     | payload
//  s_axis  | in        | s_axis_tvalid / s_axis_tready | accel_x, accel_y, accel_z
//  m_axis  | out       | m_axis_tvalid / m_axis_tready | step_seen, step_total,
//          |           |                               | cadence_spm, activity
//  cfg     | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
//  Samples are taken one at a time; with an empty peak store each goes
//  through accept, 3 squares on one shared multiplier, 16 sqrt iterations,
//  5 filter steps, then threshold, peak, step, stamp read, timeout, output.
//  Once peaks exist the threshold mean runs on the shared 32-bit serial
//  divider; a counted step with two or more stamps adds the cadence
//  division on the same divider. Reset clears the control and bookkeeping
//  state and marks RAM contents invalid, so no clearing pass is needed.
//  A result waiting on m_axis does not block the next sample until its output step.
// ----------------------------------------------------------------------------
`default_nettype none
module pedometer_step_cadence_activity_top #(
  parameter int unsigned PEAK_DEPTH    = 8,
  parameter int unsigned CADENCE_DEPTH = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // sample request
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [15:0] accel_x, [31:16] accel_y,
                                          // [47:32] accel_z
  // result request
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // [0] step_seen, [32:1] step_total,
                                          // [48:33] cadence_spm, [50:49] activity
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  ped_pkg::cmd_t cmd;
  ped_pkg::sts_t sts;

  // registers are written directly from cfg_valid_i, always ready
  assign cfg_ready_o = 1'b1;

  ped_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  ped_dp #(
    .PEAK_DEPTH    (PEAK_DEPTH),
    .CADENCE_DEPTH (CADENCE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire
